[rtl/multi_vector_coo_spmv_defines.svh]
`ifndef MULTI_VECTOR_COO_SPMV_DEFINES_SVH
`define MULTI_VECTOR_COO_SPMV_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define MVCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MVCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/mvcs_pkg.sv]
package mvcs_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 26;

  localparam int VECTOR_COUNT_DEFAULT = 8;
  localparam int MAX_LENGTH_DEFAULT   = 1024;

  localparam int CMD_BITS  = 2;
  localparam int ROW_BITS  = 10;
  localparam int VSEL_BITS = 3;
  localparam int LEN_BITS  = 11;

  localparam logic [LEN_BITS-1:0] LENGTH_RESET = 11'd1024;

  localparam int IN_ROW_LSB   = 0;
  localparam int IN_COL_LSB   = IN_ROW_LSB + ROW_BITS;
  localparam int IN_VSEL_LSB  = IN_COL_LSB + ROW_BITS;
  localparam int IN_VALUE_LSB = IN_VSEL_LSB + VSEL_BITS;
  localparam int IN_USED_BITS = IN_VALUE_LSB + VALUE_BITS;
  localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

  localparam int OUT_VALUE_LSB = 0;
  localparam int OUT_VSEL_LSB  = OUT_VALUE_LSB + VALUE_BITS;
  localparam int OUT_ROW_LSB   = OUT_VSEL_LSB + VSEL_BITS;
  localparam int OUT_USED_BITS = OUT_ROW_LSB + ROW_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_APPLY = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_ACC   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

[rtl/mvcs_ram.sv]
module mvcs_ram #(
  parameter int DATA_BITS = 256,
  parameter int DEPTH     = 1024,
  parameter int LANES     = 8,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LANE_BITS = DATA_BITS / LANES
) (
  input  logic                 clk,
  input  logic [LANES-1:0]     we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (we[i]) begin
        mem[waddr][i*LANE_BITS +: LANE_BITS] <= wdata[i*LANE_BITS +: LANE_BITS];
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/multi_vector_coo_spmv.sv]
// Channel   Dir  Payload (lowest bit first)
// s_axis    in   tdata: row_index, column_index, vector_select, value; tuser: command
// m_axis    out  tdata: result_value, result_vector, result_row; tuser: index_error
// cfg       in   cfg_wr_data: vector_length, written when cfg_wr_en is high
//
// One command is worked on at a time. Load and clear are done when accepted; apply goes
// through the read, multiply and write-back of the result memory row in turn.
// Read and out-of-range commands go through the emit step, plus any wait for the output
// register. Reset sets vector_length to 1024 and empties the output register; both
// memories stay undefined until written. A stalled output only holds back a command
// that has a result to deliver.
`include "multi_vector_coo_spmv_defines.svh"

module multi_vector_coo_spmv #(
  parameter int VECTOR_COUNT = mvcs_pkg::VECTOR_COUNT_DEFAULT,
  parameter int MAX_LENGTH   = mvcs_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // row_index, column_index, vector_select, value
  input  logic [mvcs_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // command
  input  logic [mvcs_pkg::CMD_BITS-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // result_value, result_vector, result_row
  output logic [mvcs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  // index_error
  output logic                               m_axis_tuser,
  input  logic                               cfg_wr_en,
  input  logic [mvcs_pkg::LEN_BITS-1:0]      cfg_wr_data
);

  localparam int VB        = mvcs_pkg::VALUE_BITS;
  localparam int FB        = mvcs_pkg::FRACTION_BITS;
  localparam int ADDR_BITS = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LANE_BITS = (VECTOR_COUNT > 1) ? $clog2(VECTOR_COUNT) : 1;
  localparam int ROW_W     = mvcs_pkg::ROW_BITS;
  localparam int VSEL_W    = mvcs_pkg::VSEL_BITS;

  mvcs_pkg::state_t state, state_next;

  logic [mvcs_pkg::LEN_BITS-1:0] vector_length;

  logic                 s_accept;
  mvcs_pkg::cmd_t       in_cmd;
  logic [ROW_W-1:0]     in_row;
  logic [ROW_W-1:0]     in_col;
  logic [VSEL_W-1:0]    in_vsel;
  logic [VB-1:0]        in_value;
  logic                 row_ok, col_ok, vsel_ok, in_ok;

  mvcs_pkg::cmd_t       cmd;
  logic [ROW_W-1:0]     row;
  logic [VSEL_W-1:0]    vsel;
  logic [VB-1:0]        value;
  logic                 ok;

  logic [VECTOR_COUNT-1:0]         vec_we;
  logic [VECTOR_COUNT-1:0][VB-1:0] vec_wdata;
  logic [VECTOR_COUNT-1:0][VB-1:0] vec_rdata;
  logic [VECTOR_COUNT-1:0]         res_we;
  logic [ADDR_BITS-1:0]            res_waddr;
  logic [VECTOR_COUNT-1:0][VB-1:0] res_wdata;
  logic [VECTOR_COUNT-1:0][VB-1:0] res_rdata;
  logic [VECTOR_COUNT-1:0][VB-1:0] prod;
  logic signed [2*VB-1:0]          full_prod [VECTOR_COUNT];
  logic [LANE_BITS-1:0]            in_lane;
  logic [LANE_BITS-1:0]            lane;

  logic          out_free, out_load;
  logic [VB-1:0] out_value;

  assign in_cmd   = mvcs_pkg::cmd_t'(s_axis_tuser);
  assign in_row   = s_axis_tdata[mvcs_pkg::IN_ROW_LSB +: ROW_W];
  assign in_col   = s_axis_tdata[mvcs_pkg::IN_COL_LSB +: ROW_W];
  assign in_vsel  = s_axis_tdata[mvcs_pkg::IN_VSEL_LSB +: VSEL_W];
  assign in_value = s_axis_tdata[mvcs_pkg::IN_VALUE_LSB +: VB];
  assign in_lane  = LANE_BITS'(in_vsel);
  assign lane     = LANE_BITS'(vsel);

  assign row_ok  = ({1'b0, in_row} < vector_length) && (32'(in_row) < 32'(MAX_LENGTH));
  assign col_ok  = ({1'b0, in_col} < vector_length) && (32'(in_col) < 32'(MAX_LENGTH));
  assign vsel_ok = 32'(in_vsel) < 32'(VECTOR_COUNT);

  always_comb begin
    unique case (in_cmd)
      mvcs_pkg::CMD_LOAD:  in_ok = col_ok && vsel_ok;
      mvcs_pkg::CMD_CLEAR: in_ok = row_ok;
      mvcs_pkg::CMD_APPLY: in_ok = row_ok && col_ok;
      mvcs_pkg::CMD_READ:  in_ok = row_ok && vsel_ok;
      default:             in_ok = 1'b0;
    endcase
  end

  assign s_axis_tready = (state == mvcs_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (state == mvcs_pkg::ST_EMIT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      mvcs_pkg::ST_IDLE: begin
        priority if (s_accept && in_ok && in_cmd == mvcs_pkg::CMD_APPLY) begin
          state_next = mvcs_pkg::ST_FETCH;
        end else if (s_accept && (!in_ok || in_cmd == mvcs_pkg::CMD_READ)) begin
          state_next = mvcs_pkg::ST_EMIT;
        end else begin
          state_next = mvcs_pkg::ST_IDLE;
        end
      end
      mvcs_pkg::ST_FETCH: state_next = mvcs_pkg::ST_ACC;
      mvcs_pkg::ST_ACC:   state_next = mvcs_pkg::ST_IDLE;
      mvcs_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = mvcs_pkg::ST_IDLE;
        end
      end
      default: state_next = mvcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mvcs_pkg::ST_IDLE;
      vector_length <= mvcs_pkg::LENGTH_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        vector_length <= cfg_wr_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      cmd   <= in_cmd;
      row   <= in_row;
      vsel  <= in_vsel;
      value <= in_value;
      ok    <= in_ok;
    end
  end

  // Vector memory: one row per column index, one lane per vector.
  always_comb begin
    vec_we = '0;
    if (s_accept && in_ok && in_cmd == mvcs_pkg::CMD_LOAD) begin
      vec_we[in_lane] = 1'b1;
    end
  end

  assign vec_wdata = {VECTOR_COUNT{in_value}};

  mvcs_ram #(
    .DATA_BITS (VECTOR_COUNT * VB),
    .DEPTH     (MAX_LENGTH),
    .LANES     (VECTOR_COUNT)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (ADDR_BITS'(in_col)),
    .wdata (vec_wdata),
    .re    (s_accept),
    .raddr (ADDR_BITS'(in_col)),
    .rdata (vec_rdata)
  );

  // Result memory: one row per result row, one lane per vector.
  always_comb begin
    res_we    = '0;
    res_waddr = ADDR_BITS'(in_row);
    res_wdata = '0;
    if (state == mvcs_pkg::ST_ACC) begin
      res_we    = '1;
      res_waddr = ADDR_BITS'(row);
      for (int v = 0; v < VECTOR_COUNT; v++) begin
        res_wdata[v] = res_rdata[v] + prod[v];
      end
    end else if (s_accept && in_ok && in_cmd == mvcs_pkg::CMD_CLEAR) begin
      res_we = '1;
    end
  end

  mvcs_ram #(
    .DATA_BITS (VECTOR_COUNT * VB),
    .DEPTH     (MAX_LENGTH),
    .LANES     (VECTOR_COUNT)
  ) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .re    (s_accept),
    .raddr (ADDR_BITS'(in_row)),
    .rdata (res_rdata)
  );

  // Full-width signed product, shifted down by the fraction bits (floor).
  always_comb begin
    for (int v = 0; v < VECTOR_COUNT; v++) begin
      full_prod[v] = signed'(value) * signed'(vec_rdata[v]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mvcs_pkg::ST_FETCH) begin
      for (int v = 0; v < VECTOR_COUNT; v++) begin
        prod[v] <= full_prod[v][FB +: VB];
      end
    end
  end

  assign out_value = (cmd == mvcs_pkg::CMD_READ && ok) ? res_rdata[lane] : '0;

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {
        (mvcs_pkg::OUT_DATA_BITS - mvcs_pkg::OUT_USED_BITS)'(0),
        row, vsel, out_value
      };
      m_axis_tuser <= !ok;
    end
  end

  `MVCS_ASSERT(a_out_not_overwritten, out_load |-> (!m_axis_tvalid || m_axis_tready),
    "output register loaded while an unread beat was held")
  `MVCS_ASSERT(a_valid_from_emit,
    $rose(m_axis_tvalid) |-> $past(state == mvcs_pkg::ST_EMIT),
    "output beat raised outside the emit step")
  `MVCS_ASSERT(a_acc_after_fetch,
    (state == mvcs_pkg::ST_ACC) |-> $past(state == mvcs_pkg::ST_FETCH),
    "write-back without a preceding multiply step")
  `MVCS_ASSERT(a_apply_interlock,
    (s_accept && in_ok && in_cmd == mvcs_pkg::CMD_APPLY) |=> !s_axis_tready ##1 !s_axis_tready,
    "new command taken during an apply read-modify-write")

endmodule

[bench/multi_vector_coo_spmv_tb.sv]
`timescale 1ns / 1ps

module multi_vector_coo_spmv_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int IDLE_SETTLE = 8;
  localparam int VCOUNT      = mvcs_pkg::VECTOR_COUNT_DEFAULT;
  localparam int MAXLEN      = mvcs_pkg::MAX_LENGTH_DEFAULT;

  typedef struct packed {
    logic [mvcs_pkg::VALUE_BITS-1:0] value;
    logic [mvcs_pkg::VSEL_BITS-1:0]  vec;
    logic [mvcs_pkg::ROW_BITS-1:0]   row;
    logic                            index_error;
  } readback_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [mvcs_pkg::IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic [mvcs_pkg::CMD_BITS-1:0]      s_axis_tuser = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [mvcs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                               m_axis_tuser;
  logic                               cfg_wr_en = 1'b0;
  logic [mvcs_pkg::LEN_BITS-1:0]      cfg_wr_data = '0;

  logic [mvcs_pkg::VALUE_BITS-1:0] vector_shadow [VCOUNT][MAXLEN];
  logic [mvcs_pkg::VALUE_BITS-1:0] sum_shadow [VCOUNT][MAXLEN];
  bit                              element_loaded [VCOUNT][MAXLEN];
  bit                              row_cleared [MAXLEN];
  logic [mvcs_pkg::LEN_BITS-1:0]   length_shadow = mvcs_pkg::LENGTH_RESET;

  readback_t expected_readbacks [$];
  readback_t want;
  int        mismatches = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        cycle_count = 0;

  logic [mvcs_pkg::VALUE_BITS-1:0] corner_values [8] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h0400_0000, 32'hFC00_0000, 32'h0000_0001, 32'h1234_5678
  };

  multi_vector_coo_spmv dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic int active_length();
    return (length_shadow > MAXLEN) ? MAXLEN : int'(length_shadow);
  endfunction

  function automatic int pick_index(bit out_of_range);
    int len;
    len = active_length();
    if (out_of_range) begin
      return $urandom_range(MAXLEN - 1, len);
    end
    return $urandom_range(len - 1, 0);
  endfunction

  function automatic logic [mvcs_pkg::VALUE_BITS-1:0] random_value();
    case ($urandom_range(3))
      0: return corner_values[$urandom_range(7)];
      1: return $urandom_range(32'h0800_0000) - 32'h0400_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit column_ready(int col);
    for (int v = 0; v < VCOUNT; v++) begin
      if (!element_loaded[v][col]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Products are floored by the arithmetic shift; sums wrap at the value width.
  task automatic spmv_predict(mvcs_pkg::cmd_t cmd, logic [mvcs_pkg::ROW_BITS-1:0] row,
                              logic [mvcs_pkg::ROW_BITS-1:0] col,
                              logic [mvcs_pkg::VSEL_BITS-1:0] vsel,
                              logic [mvcs_pkg::VALUE_BITS-1:0] value);
    int                                       len;
    bit                                       in_range;
    logic [mvcs_pkg::VALUE_BITS-1:0]          read_value;
    logic signed [2*mvcs_pkg::VALUE_BITS-1:0] product;
    len = active_length();
    read_value = '0;
    case (cmd)
      mvcs_pkg::CMD_LOAD: begin
        in_range = (col < len) && (vsel < VCOUNT);
        if (in_range) begin
          vector_shadow[vsel][col] = value;
          element_loaded[vsel][col] = 1'b1;
        end
      end
      mvcs_pkg::CMD_CLEAR: begin
        in_range = row < len;
        if (in_range) begin
          for (int v = 0; v < VCOUNT; v++) begin
            sum_shadow[v][row] = '0;
          end
          row_cleared[row] = 1'b1;
        end
      end
      mvcs_pkg::CMD_APPLY: begin
        in_range = (row < len) && (col < len);
        if (in_range) begin
          for (int v = 0; v < VCOUNT; v++) begin
            product = $signed(value) * $signed(vector_shadow[v][col]);
            sum_shadow[v][row] = sum_shadow[v][row] +
                                 product[mvcs_pkg::FRACTION_BITS +: mvcs_pkg::VALUE_BITS];
          end
        end
      end
      default: begin
        in_range = (row < len) && (vsel < VCOUNT);
        if (in_range) begin
          read_value = sum_shadow[vsel][row];
        end
      end
    endcase
    if (cmd == mvcs_pkg::CMD_READ || !in_range) begin
      expected_readbacks.push_back('{read_value, vsel, row, !in_range});
    end
  endtask

  task automatic send_command(mvcs_pkg::cmd_t cmd, int unsigned row, int unsigned col,
                              int unsigned vsel, logic [mvcs_pkg::VALUE_BITS-1:0] value);
    logic [mvcs_pkg::IN_DATA_BITS-1:0] beat;
    logic [mvcs_pkg::ROW_BITS-1:0]     row_field;
    logic [mvcs_pkg::ROW_BITS-1:0]     col_field;
    logic [mvcs_pkg::VSEL_BITS-1:0]    vsel_field;
    row_field = row[mvcs_pkg::ROW_BITS-1:0];
    col_field = col[mvcs_pkg::ROW_BITS-1:0];
    vsel_field = vsel[mvcs_pkg::VSEL_BITS-1:0];
    beat = '0;
    beat[mvcs_pkg::IN_ROW_LSB +: mvcs_pkg::ROW_BITS] = row_field;
    beat[mvcs_pkg::IN_COL_LSB +: mvcs_pkg::ROW_BITS] = col_field;
    beat[mvcs_pkg::IN_VSEL_LSB +: mvcs_pkg::VSEL_BITS] = vsel_field;
    beat[mvcs_pkg::IN_VALUE_LSB +: mvcs_pkg::VALUE_BITS] = value;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = beat;
    s_axis_tuser = cmd;
    do @(posedge clk); while (!s_axis_tready);
    spmv_predict(cmd, row_field, col_field, vsel_field, value);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(5)) @(negedge clk);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(64, 32) : $urandom_range(12);
    end
  endtask

  task automatic drain_readbacks();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_readbacks.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(int len);
    drain_readbacks();
    repeat (IDLE_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = mvcs_pkg::LEN_BITS'(len);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    length_shadow = mvcs_pkg::LEN_BITS'(len);
  endtask

  task automatic prepare_row(output int row);
    row = pick_index(1'b0);
    for (int t = 0; t < 4 && !row_cleared[row]; t++) begin
      row = pick_index(1'b0);
    end
    if (!row_cleared[row]) begin
      send_command(mvcs_pkg::CMD_CLEAR, row, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic run_random_commands(int count);
    int stop_at;
    int pick;
    int row;
    int col;
    bit oor;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      oor = (active_length() < MAXLEN) && ($urandom_range(9) == 0);
      if (pick < 12) begin
        send_command(mvcs_pkg::CMD_LOAD, $urandom, pick_index(oor), $urandom, random_value());
      end else if (pick < 20) begin
        send_command(mvcs_pkg::CMD_CLEAR, pick_index(oor), $urandom, $urandom, $urandom);
      end else if (pick < 65) begin
        if (oor) begin
          if ($urandom_range(1)) begin
            send_command(mvcs_pkg::CMD_APPLY, pick_index(1'b1), pick_index(1'b0), $urandom,
                         $urandom);
          end else begin
            send_command(mvcs_pkg::CMD_APPLY, pick_index(1'b0), pick_index(1'b1), $urandom,
                         $urandom);
          end
        end else begin
          col = pick_index(1'b0);
          for (int t = 0; t < 4 && !column_ready(col); t++) begin
            col = pick_index(1'b0);
          end
          if (!column_ready(col)) begin
            for (int v = 0; v < VCOUNT; v++) begin
              send_command(mvcs_pkg::CMD_LOAD, $urandom, col, v, random_value());
            end
          end
          prepare_row(row);
          send_command(mvcs_pkg::CMD_APPLY, row, col, $urandom, random_value());
        end
      end else begin
        if (oor) begin
          row = pick_index(1'b1);
        end else begin
          prepare_row(row);
        end
        send_command(mvcs_pkg::CMD_READ, row, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_directed_reset_length();
    for (int v = 0; v < VCOUNT; v++) begin
      send_command(mvcs_pkg::CMD_LOAD, 0, MAXLEN - 1, v, corner_values[v]);
    end
    send_command(mvcs_pkg::CMD_CLEAR, MAXLEN - 1, 0, 0, 0);
    send_command(mvcs_pkg::CMD_CLEAR, 0, 0, 0, 0);
    send_command(mvcs_pkg::CMD_APPLY, MAXLEN - 1, MAXLEN - 1, 0, 32'h8000_0000);
    send_command(mvcs_pkg::CMD_APPLY, 0, MAXLEN - 1, 0, 32'h7FFF_FFFF);
    send_command(mvcs_pkg::CMD_APPLY, 0, MAXLEN - 1, 0, 32'hFFFF_FFFF);
    for (int v = 0; v < VCOUNT; v++) begin
      send_command(mvcs_pkg::CMD_READ, MAXLEN - 1, 0, v, 0);
    end
    send_command(mvcs_pkg::CMD_READ, 0, 0, 2, 0);
    send_command(mvcs_pkg::CMD_READ, 0, 0, 5, 0);
  endtask

  task automatic test_length_corners();
    write_length(0);
    send_command(mvcs_pkg::CMD_LOAD, 0, 0, 0, 32'h0400_0000);
    send_command(mvcs_pkg::CMD_CLEAR, 0, 0, 0, 0);
    send_command(mvcs_pkg::CMD_APPLY, 0, 0, 0, 32'h0400_0000);
    send_command(mvcs_pkg::CMD_READ, 0, 0, 0, 0);
    write_length(2047);
    send_command(mvcs_pkg::CMD_READ, MAXLEN - 1, 0, 1, 0);
    write_length(1);
    send_command(mvcs_pkg::CMD_READ, 0, 0, 3, 0);
    send_command(mvcs_pkg::CMD_READ, 1, 0, 3, 0);
    send_command(mvcs_pkg::CMD_LOAD, 0, 1, 4, 32'h1234_5678);
    send_command(mvcs_pkg::CMD_CLEAR, 1, 0, 0, 0);
    send_command(mvcs_pkg::CMD_APPLY, 0, 1, 0, 32'h0400_0000);
    send_command(mvcs_pkg::CMD_APPLY, 1, 0, 0, 32'h0400_0000);
  endtask

  task automatic test_random_short_vectors();
    write_length(16);
    run_random_commands(250);
    drain_readbacks();
    run_random_commands(250);
    write_length(1);
    run_random_commands(100);
    write_length($urandom_range(64, 2));
    run_random_commands(300);
    write_length(MAXLEN - 1);
    run_random_commands(150);
  endtask

  task automatic test_random_full_length();
    write_length(MAXLEN);
    run_random_commands(450);
  endtask

  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(200, 20);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = $urandom_range(1);
          2: m_axis_tready = ($urandom_range(3) == 0);
          default: m_axis_tready = ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_readbacks.size() == 0) begin
        $error("Unexpected result beat: tdata %h, tuser %b", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_readbacks.pop_front();
        if (m_axis_tdata[mvcs_pkg::OUT_VALUE_LSB +: mvcs_pkg::VALUE_BITS] !== want.value) begin
          $error("result_value: expected %h, got %h", want.value,
                 m_axis_tdata[mvcs_pkg::OUT_VALUE_LSB +: mvcs_pkg::VALUE_BITS]);
          mismatches++;
        end
        if (m_axis_tdata[mvcs_pkg::OUT_VSEL_LSB +: mvcs_pkg::VSEL_BITS] !== want.vec) begin
          $error("result_vector: expected %0d, got %0d", want.vec,
                 m_axis_tdata[mvcs_pkg::OUT_VSEL_LSB +: mvcs_pkg::VSEL_BITS]);
          mismatches++;
        end
        if (m_axis_tdata[mvcs_pkg::OUT_ROW_LSB +: mvcs_pkg::ROW_BITS] !== want.row) begin
          $error("result_row: expected %0d, got %0d", want.row,
                 m_axis_tdata[mvcs_pkg::OUT_ROW_LSB +: mvcs_pkg::ROW_BITS]);
          mismatches++;
        end
        if (m_axis_tuser !== want.index_error) begin
          $error("index_error: expected %b, got %b", want.index_error, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_reset_length();
    test_length_corners();
    test_random_short_vectors();
    test_random_full_length();
    drain_readbacks();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/mvcs_pkg.sv
rtl/mvcs_ram.sv
rtl/multi_vector_coo_spmv.sv
bench/multi_vector_coo_spmv_tb.sv
